[hdl/ldik_pkg.sv]
// ldik_pkg: widths, register indexes and pipeline beat types for the
// linear delta inverse kinematics block. No dependencies.
`timescale 1ns / 1ps

package ldik_pkg;

   localparam int COORD_BITS   = 20;
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int ROD_BITS     = COORD_BITS - 1;
   localparam int SQ_BITS      = 2 * ROD_BITS;
   localparam int RAD_BITS     = SQ_BITS;
   localparam int ROOT_BITS    = ROD_BITS;
   localparam int REM_BITS     = ROOT_BITS + 2;
   localparam int CAR_BITS     = COORD_BITS + 1;
   localparam int POS_BITS     = COORD_BITS + 2;
   localparam int NUM_TOWERS   = 3;
   localparam int CSR_IDX_BITS = 4;

   // pipeline layout: three front stages, one root cell per root bit, output register
   localparam int FRONT_STAGES = 3;
   localparam int NUM_CELLS    = ROOT_BITS;
   localparam int NUM_STAGES   = FRONT_STAGES + NUM_CELLS + 1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_TOWER_A_X     = 4'd0,
      CSR_TOWER_A_Y     = 4'd1,
      CSR_TOWER_B_X     = 4'd2,
      CSR_TOWER_B_Y     = 4'd3,
      CSR_TOWER_C_X     = 4'd4,
      CSR_TOWER_C_Y     = 4'd5,
      CSR_ROD_LENGTH    = 4'd6,
      CSR_HEIGHT_OFFSET = 4'd7
   } csr_index_type;

   // tower geometry as seen by the front stages
   typedef struct packed {
      logic [NUM_TOWERS-1:0][COORD_BITS-1:0] tower_x;
      logic [NUM_TOWERS-1:0][COORD_BITS-1:0] tower_y;
      logic [ROD_BITS-1:0]                   rod;
   } geom_type;

   // one tower's square root in progress
   typedef struct packed {
      logic [RAD_BITS-1:0]  rad;
      logic [REM_BITS-1:0]  rem;
      logic [ROOT_BITS-1:0] root;
   } lane_type;

   // beat handed from cell to cell
   typedef struct packed {
      lane_type [NUM_TOWERS-1:0] lane;
      logic [COORD_BITS-1:0]     tz;
      logic [NUM_TOWERS-1:0]     far;
   } cell_type;

endpackage

[hdl/linear_delta_inverse_kinematics.sv]
// linear_delta_inverse_kinematics: top level, configuration registers and
// pipeline control. Depends on ldik_pkg, ldik_front, ldik_root_cell, ldik_output.
`timescale 1ns / 1ps

// Takes one target point per beat and returns the three carriage positions of
// a linear delta robot, 1/256 mm fixed point, with a per-tower out-of-reach
// flag (height taken as zero). A new point is taken every cycle while req_stall
// is low. Each point passes three front stages (distance, squares, radicand), a
// chain of 19 root cells that produce one root bit each, and the output register.
// A stage holds only while the stage after it is full and stalled, so bubbles
// close up. The user writes the geometry registers through the csr_ port only
// while no point is in flight; the block does not enforce this. Reset clears them.

module linear_delta_inverse_kinematics import ldik_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [COORD_BITS-1:0]   req_target_x,
   input  logic [COORD_BITS-1:0]   req_target_y,
   input  logic [COORD_BITS-1:0]   req_target_z,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [CAR_BITS-1:0]     rsp_carriage_a,
   output logic [CAR_BITS-1:0]     rsp_carriage_b,
   output logic [CAR_BITS-1:0]     rsp_carriage_c,
   output logic [NUM_TOWERS-1:0]   rsp_out_of_reach,
   input  logic                    csr_write,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]   csr_wdata
);

   geom_type                            geom_ff;
   logic [COORD_BITS-1:0]               offset_ff;
   logic [NUM_STAGES-1:0]               valid_ff, valid_in;
   logic [NUM_STAGES-1:0]               en;
   cell_type [NUM_CELLS:0]              chain;
   logic [NUM_TOWERS-1:0][CAR_BITS-1:0] carriage;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff   <= '0;
         offset_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TOWER_A_X:     geom_ff.tower_x[0] <= csr_wdata;
            CSR_TOWER_A_Y:     geom_ff.tower_y[0] <= csr_wdata;
            CSR_TOWER_B_X:     geom_ff.tower_x[1] <= csr_wdata;
            CSR_TOWER_B_Y:     geom_ff.tower_y[1] <= csr_wdata;
            CSR_TOWER_C_X:     geom_ff.tower_x[2] <= csr_wdata;
            CSR_TOWER_C_Y:     geom_ff.tower_y[2] <= csr_wdata;
            CSR_ROD_LENGTH:    geom_ff.rod        <= csr_wdata[ROD_BITS-1:0];
            CSR_HEIGHT_OFFSET: offset_ff          <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage enables: a stage loads when it is empty or its successor loads
   assign en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
   for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_en
      assign en[k] = !valid_ff[k] || en[k+1];
   end

   assign valid_in = {valid_ff[NUM_STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   // distance, square and radicand stages
   ldik_front u_front (
      .clock    (clock),
      .en       (en[FRONT_STAGES-1:0]),
      .target_x (req_target_x),
      .target_y (req_target_y),
      .target_z (req_target_z),
      .geom     (geom_ff),
      .head     (chain[0])
   );

   // square root chain, one result bit per cell
   for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
      ldik_root_cell u_cell (
         .clock (clock),
         .en    (en[FRONT_STAGES+c]),
         .prev  (chain[c]),
         .next  (chain[c+1])
      );
   end

   // carriage positions and output register
   ldik_output u_output (
      .clock    (clock),
      .en       (en[NUM_STAGES-1]),
      .tail     (chain[NUM_CELLS]),
      .offset   (offset_ff),
      .carriage (carriage),
      .far      (rsp_out_of_reach)
   );

   assign rsp_carriage_a = carriage[0];
   assign rsp_carriage_b = carriage[1];
   assign rsp_carriage_c = carriage[2];

endmodule

[hdl/ldik_front.sv]
// ldik_front: tower distances, squares and radicands, three pipeline stages.
// Depends on ldik_pkg.
`timescale 1ns / 1ps

module ldik_front import ldik_pkg::*; (
   input  logic                    clock,
   input  logic [FRONT_STAGES-1:0] en,
   input  logic [COORD_BITS-1:0]   target_x,
   input  logic [COORD_BITS-1:0]   target_y,
   input  logic [COORD_BITS-1:0]   target_z,
   input  geom_type                geom,
   output cell_type                head
);

   logic [NUM_TOWERS-1:0][ROD_BITS-1:0] mx_ff, mx_in, my_ff, my_in;
   logic [NUM_TOWERS-1:0]               far0_ff, far0_in, far1_ff;
   logic [COORD_BITS-1:0]               tz0_ff, tz1_ff;
   logic [NUM_TOWERS-1:0][SQ_BITS-1:0]  sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [SQ_BITS-1:0]                  r2_ff, r2_in;
   cell_type                            head_ff, head_in;

   // stage 0: signed differences, magnitudes and reach check
   always_comb begin
      logic [DIFF_BITS-1:0] dx, dy, ax, ay;
      for (int i = 0; i < NUM_TOWERS; i++) begin
         dx = {target_x[COORD_BITS-1], target_x}
              - {geom.tower_x[i][COORD_BITS-1], geom.tower_x[i]};
         dy = {target_y[COORD_BITS-1], target_y}
              - {geom.tower_y[i][COORD_BITS-1], geom.tower_y[i]};
         ax = dx[DIFF_BITS-1] ? -dx : dx;
         ay = dy[DIFF_BITS-1] ? -dy : dy;
         mx_in[i]   = ax[ROD_BITS-1:0];
         my_in[i]   = ay[ROD_BITS-1:0];
         far0_in[i] = (ax > {2'b00, geom.rod}) || (ay > {2'b00, geom.rod});
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         mx_ff   <= mx_in;
         my_ff   <= my_in;
         far0_ff <= far0_in;
         tz0_ff  <= target_z;
      end
   end

   // stage 1: squares of the distances and of the rod
   always_comb begin
      for (int i = 0; i < NUM_TOWERS; i++) begin
         sqx_in[i] = SQ_BITS'(mx_ff[i]) * SQ_BITS'(mx_ff[i]);
         sqy_in[i] = SQ_BITS'(my_ff[i]) * SQ_BITS'(my_ff[i]);
      end
      r2_in = SQ_BITS'(geom.rod) * SQ_BITS'(geom.rod);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         sqx_ff  <= sqx_in;
         sqy_ff  <= sqy_in;
         r2_ff   <= r2_in;
         far1_ff <= far0_ff;
         tz1_ff  <= tz0_ff;
      end
   end

   // stage 2: radicand, forced to zero when the point is out of reach
   always_comb begin
      logic [SQ_BITS:0] d2, diff;
      logic             neg;
      head_in    = '0;
      head_in.tz = tz1_ff;
      for (int i = 0; i < NUM_TOWERS; i++) begin
         d2   = {1'b0, sqx_ff[i]} + {1'b0, sqy_ff[i]};
         neg  = d2 > {1'b0, r2_ff};
         diff = {1'b0, r2_ff} - d2;
         head_in.far[i]      = far1_ff[i] || neg;
         head_in.lane[i].rad = head_in.far[i] ? '0 : diff[RAD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         head_ff <= head_in;
      end
   end

   assign head = head_ff;

endmodule

[hdl/ldik_root_cell.sv]
// ldik_root_cell: one bit of the restoring square root for all three towers.
// Depends on ldik_pkg.
`timescale 1ns / 1ps

module ldik_root_cell import ldik_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  cell_type prev,
   output cell_type next
);

   cell_type next_ff, next_in;

   // bring down two radicand bits, try root*4+1 against the remainder
   always_comb begin
      logic [REM_BITS+1:0] wide, trial, left;
      logic                fit;
      next_in = prev;
      for (int i = 0; i < NUM_TOWERS; i++) begin
         wide  = {prev.lane[i].rem, prev.lane[i].rad[RAD_BITS-1 -: 2]};
         trial = {2'b00, prev.lane[i].root, 2'b01};
         fit   = wide >= trial;
         left  = fit ? wide - trial : wide;
         next_in.lane[i].rem  = left[REM_BITS-1:0];
         next_in.lane[i].root = {prev.lane[i].root[ROOT_BITS-2:0], fit};
         next_in.lane[i].rad  = {prev.lane[i].rad[RAD_BITS-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         next_ff <= next_in;
      end
   end

   assign next = next_ff;

endmodule

[hdl/ldik_output.sv]
// ldik_output: carriage positions with saturation, and the output register.
// Depends on ldik_pkg.
`timescale 1ns / 1ps

module ldik_output import ldik_pkg::*; (
   input  logic                                clock,
   input  logic                                en,
   input  cell_type                            tail,
   input  logic [COORD_BITS-1:0]               offset,
   output logic [NUM_TOWERS-1:0][CAR_BITS-1:0] carriage,
   output logic [NUM_TOWERS-1:0]               far
);

   localparam logic signed [POS_BITS-1:0] POS_HI = POS_BITS'((1 << COORD_BITS) - 1);
   localparam logic signed [POS_BITS-1:0] POS_LO = -POS_BITS'(1 << COORD_BITS);

   logic [NUM_TOWERS-1:0][CAR_BITS-1:0] carriage_ff, carriage_in;
   logic [NUM_TOWERS-1:0]               far_ff;

   // offset + z - height, clamped to the carriage range
   always_comb begin
      logic signed [POS_BITS-1:0] pos;
      for (int i = 0; i < NUM_TOWERS; i++) begin
         pos = POS_BITS'($signed(offset)) + POS_BITS'($signed(tail.tz))
               - $signed(POS_BITS'(tail.lane[i].root));
         if (pos > POS_HI) begin
            carriage_in[i] = POS_HI[CAR_BITS-1:0];
         end else if (pos < POS_LO) begin
            carriage_in[i] = POS_LO[CAR_BITS-1:0];
         end else begin
            carriage_in[i] = pos[CAR_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         carriage_ff <= carriage_in;
         far_ff      <= tail.far;
      end
   end

   assign carriage = carriage_ff;
   assign far      = far_ff;

endmodule

[dv/linear_delta_inverse_kinematics_test.sv]
// linear_delta_inverse_kinematics_test: self-checking bench for the delta robot
// inverse kinematics block, with a bit-exact carriage predictor built in.
// Depends on ldik_pkg and linear_delta_inverse_kinematics.
`timescale 1ns / 1ps

module linear_delta_inverse_kinematics_test;
   import ldik_pkg::*;

   localparam int     HALF_PERIOD      = 10;
   localparam int     RESET_CYCLES     = 9;
   // sized for ~720 points, each at most a long sender gap, a long receiver stall
   // and the pipeline depth, plus drains
   localparam int     CYCLE_LIMIT      = 400000;
   localparam int     HOLD_OFF_CYCLES  = 150;
   localparam int     RANDOM_PHASES    = 7;
   localparam int     POINTS_PER_PHASE = 100;
   localparam int     NUM_CSRS         = CSR_HEIGHT_OFFSET + 1;
   localparam int     LAST_CSR_INDEX   = (1 << CSR_IDX_BITS) - 1;
   localparam longint CAR_MAX          = (longint'(1) << COORD_BITS) - 1;
   localparam longint CAR_MIN          = -(longint'(1) << COORD_BITS);
   localparam int     NUM_DIRECTED     = 20;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [CAR_BITS-1:0]   a;
      logic [CAR_BITS-1:0]   b;
      logic [CAR_BITS-1:0]   c;
      logic [NUM_TOWERS-1:0] oor;
   } carriage_set_type;

   // geometry settings the stimulus moves through
   typedef enum logic [2:0] {
      GEOM_RESET,
      GEOM_DELTA,
      GEOM_CORNER,
      GEOM_CEILING,
      GEOM_RANDOM
   } geom_pick_type;

   typedef struct packed {
      geom_pick_type    geom;
      coord_type        x;
      coord_type        y;
      coord_type        z;
      logic             typed;
      carriage_set_type want;
   } directed_row_type;

   // directed points; typed rows carry their result, the rest use the predictor
   localparam directed_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      // all registers zero: rod of zero length, every carriage follows z
      '{GEOM_RESET, 20'h0, 20'h0, 20'h0, 1'b1,
        '{21'h000000, 21'h000000, 21'h000000, 3'b000}},
      '{GEOM_RESET, 20'h0, 20'h0, 20'h7FFFF, 1'b1,
        '{21'h07FFFF, 21'h07FFFF, 21'h07FFFF, 3'b000}},
      '{GEOM_RESET, 20'h0, 20'h0, 20'h80000, 1'b1,
        '{21'h180000, 21'h180000, 21'h180000, 3'b000}},
      '{GEOM_RESET, 20'd1, 20'h0, 20'd100, 1'b1,
        '{21'd100, 21'd100, 21'd100, 3'b111}},
      '{GEOM_RESET, 20'h80000, 20'h7FFFF, 20'hFFFFF, 1'b1,
        '{21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 3'b111}},
      '{GEOM_RESET, 20'h7FFFF, 20'h80000, 20'h0, 1'b1,
        '{21'h000000, 21'h000000, 21'h000000, 3'b111}},
      // usual delta layout: center, under a tower, on and just past the reach
      '{GEOM_DELTA, 20'd0, 20'd0, 20'd0, 1'b0, '0},
      '{GEOM_DELTA, 20'd0, 20'd38400, -20'sd5000, 1'b0, '0},
      '{GEOM_DELTA, 20'd64000, 20'd38400, 20'd0, 1'b0, '0},
      '{GEOM_DELTA, 20'd64001, 20'd38400, 20'd0, 1'b0, '0},
      '{GEOM_DELTA, 20'd0, 20'd102400, 20'h7FFFF, 1'b0, '0},
      '{GEOM_DELTA, 20'h80000, 20'h80000, 20'h80000, 1'b0, '0},
      // towers at two corners and 0,0, longest rod, lowest offset: clipping low
      '{GEOM_CORNER, 20'h80000, 20'h80000, 20'h80000, 1'b1,
        '{21'h100000, 21'h100000, 21'h100000, 3'b110}},
      '{GEOM_CORNER, 20'h0, 20'h0, 20'h0, 1'b0, '0},
      '{GEOM_CORNER, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 1'b0, '0},
      '{GEOM_CORNER, 20'hFFFFF, 20'hFFFFF, 20'h12345, 1'b0, '0},
      // highest offset, unit rod: top of the carriage range
      '{GEOM_CEILING, 20'd0, 20'd0, 20'h7FFFF, 1'b0, '0},
      '{GEOM_CEILING, 20'd1, 20'd0, 20'h7FFFF, 1'b0, '0},
      '{GEOM_CEILING, 20'd1, 20'd1, 20'h7FFFF, 1'b0, '0},
      '{GEOM_CEILING, 20'd257, 20'd0, 20'h80000, 1'b0, '0}
   };

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [COORD_BITS-1:0]   req_target_x;
   logic [COORD_BITS-1:0]   req_target_y;
   logic [COORD_BITS-1:0]   req_target_z;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [CAR_BITS-1:0]     rsp_carriage_a;
   logic [CAR_BITS-1:0]     rsp_carriage_b;
   logic [CAR_BITS-1:0]     rsp_carriage_c;
   logic [NUM_TOWERS-1:0]   rsp_out_of_reach;
   logic                    csr_write;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [COORD_BITS-1:0]   csr_wdata;

   // shadow of the geometry registers
   coord_type           tower_x_reg [NUM_TOWERS];
   coord_type           tower_y_reg [NUM_TOWERS];
   logic [ROD_BITS-1:0] rod_reg;
   coord_type           offset_reg;

   carriage_set_type pending_carriages [$];

   logic        hold_off_request;
   logic        hold_off_done;
   int unsigned quiet_left;
   int unsigned fault_count;
   int unsigned checked_count;
   int unsigned far_count;
   int unsigned clipped_count;
   int unsigned settings_loaded;
   int unsigned backpressure_cycles;
   int unsigned cycle_count;

   linear_delta_inverse_kinematics dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_target_x     (req_target_x),
      .req_target_y     (req_target_y),
      .req_target_z     (req_target_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_carriage_a   (rsp_carriage_a),
      .rsp_carriage_b   (rsp_carriage_b),
      .rsp_carriage_c   (rsp_carriage_c),
      .rsp_out_of_reach (rsp_out_of_reach),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_carriages.size());
         $display("linear_delta_inverse_kinematics verification failed");
         $finish;
      end
   end

   // integer square root, rounded down, one root bit per step from the top
   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned r;
      longint unsigned trial;
      r = 0;
      for (int b = ROOT_BITS - 1; b >= 0; b--) begin
         trial = r | (64'd1 << b);
         if (trial * trial <= n) r = trial;
      end
      return r;
   endfunction

   // carriage of one tower; far when the rod cannot reach the target
   function automatic logic [CAR_BITS-1:0] place_carriage(
      input coord_type tx, input coord_type ty, input coord_type tz,
      input coord_type ax, input coord_type ay, output logic far, output logic clipped);
      longint reach;
      longint dx;
      longint dy;
      longint lift;
      longint pos;
      reach = longint'(rod_reg);
      dx = longint'(tx) - longint'(ax);
      dy = longint'(ty) - longint'(ay);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      lift = 0;
      far = 1'b1;
      // guard on each axis first, then the circle itself
      if (dx <= reach && dy <= reach) begin
         if (dx * dx + dy * dy <= reach * reach) begin
            lift = longint'(root_floor(reach * reach - dx * dx - dy * dy));
            far = 1'b0;
         end
      end
      pos = longint'(offset_reg) - lift + longint'(tz);
      clipped = (pos > CAR_MAX) || (pos < CAR_MIN);
      if (pos > CAR_MAX) pos = CAR_MAX;
      if (pos < CAR_MIN) pos = CAR_MIN;
      return CAR_BITS'(pos);
   endfunction

   // expected carriages for one target point under the current geometry
   function automatic carriage_set_type solve_point(input coord_type x, input coord_type y,
                                                    input coord_type z);
      logic [CAR_BITS-1:0]   car [NUM_TOWERS];
      logic [NUM_TOWERS-1:0] flags;
      logic                  far;
      logic                  clipped;
      for (int i = 0; i < NUM_TOWERS; i++) begin
         car[i] = place_carriage(x, y, z, tower_x_reg[i], tower_y_reg[i], far, clipped);
         flags[i] = far;
         far_count += far;
         clipped_count += clipped;
      end
      return '{car[0], car[1], car[2], flags};
   endfunction

   // sender gap: mostly none or short, a few long, now and then a gapless run
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         quiet_left = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // offer one point and log its expected carriages once the beat is taken
   task automatic send_point(input coord_type x, input coord_type y, input coord_type z,
                             input logic typed, input carriage_set_type typed_set);
      int unsigned gap;
      gap = (hold_off_request && !hold_off_done) ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    = 1'b1;
      req_target_x = x;
      req_target_y = y;
      req_target_z = z;
      @(posedge clock);
      while (req_stall !== 1'b0) begin
         if (hold_off_request && !hold_off_done) backpressure_cycles++;
         @(posedge clock);
      end
      pending_carriages.push_back(typed ? typed_set : solve_point(x, y, z));
      @(negedge clock);
   endtask

   // stop offering and let every outstanding point come out
   task automatic settle_pipeline();
      req_valid = 1'b0;
      while (pending_carriages.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input int unsigned idx, input logic [COORD_BITS-1:0] value);
      csr_write = 1'b1;
      csr_index = CSR_IDX_BITS'(idx);
      csr_wdata = value;
      case (idx)
         CSR_TOWER_A_X:     tower_x_reg[0] = value;
         CSR_TOWER_A_Y:     tower_y_reg[0] = value;
         CSR_TOWER_B_X:     tower_x_reg[1] = value;
         CSR_TOWER_B_Y:     tower_y_reg[1] = value;
         CSR_TOWER_C_X:     tower_x_reg[2] = value;
         CSR_TOWER_C_Y:     tower_y_reg[2] = value;
         CSR_ROD_LENGTH:    rod_reg = value[ROD_BITS-1:0];
         CSR_HEIGHT_OFFSET: offset_reg = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // write every register, then one stray write to an unused index
   task automatic load_geometry(input geom_pick_type pick);
      logic [COORD_BITS-1:0] vals [NUM_CSRS];
      logic                  compact;
      case (pick)
         GEOM_DELTA: vals = '{20'd0, 20'd38400, -20'sd33255, -20'sd19200,
                              20'd33255, -20'sd19200, 20'd64000, 20'd76800};
         // rod written with the unused top data bit set
         GEOM_CORNER: vals = '{20'h80000, 20'h80000, 20'h7FFFF, 20'h7FFFF,
                               20'h0, 20'h0, 20'hFFFFF, 20'h80000};
         GEOM_CEILING: vals = '{20'd0, 20'd0, 20'd256, 20'd0,
                                20'd0, 20'd256, 20'd1, 20'h7FFFF};
         default: begin
            compact = ($urandom_range(0, 2) != 0);
            for (int r = CSR_TOWER_A_X; r <= CSR_TOWER_C_Y; r++) begin
               vals[r] = COORD_BITS'($urandom);
               if (compact) vals[r] = {{3{vals[r][16]}}, vals[r][16:0]};
            end
            vals[CSR_ROD_LENGTH] = ($urandom_range(0, 3) == 0) ?
                                   COORD_BITS'($urandom_range(0, 2000)) :
                                   COORD_BITS'($urandom);
            vals[CSR_HEIGHT_OFFSET] = COORD_BITS'($urandom);
         end
      endcase
      for (int r = CSR_TOWER_A_X; r <= CSR_HEIGHT_OFFSET; r++) write_reg(r, vals[r]);
      write_reg($urandom_range(NUM_CSRS, LAST_CSR_INDEX), COORD_BITS'($urandom));
      csr_write = 1'b0;
      settings_loaded++;
      repeat (2) @(negedge clock);
   endtask

   // receiver: random stall runs, plus one long hold-off on request
   initial begin
      int unsigned stall_left;
      stall_left    = 0;
      rsp_stall     = 1'b0;
      hold_off_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request && !hold_off_done) begin
            rsp_stall = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_done = 1'b1;
            rsp_stall     = 1'b0;
            stall_left    = $urandom_range(20, 40);
         end else if (stall_left > 0) begin
            stall_left--;
         end else if (rsp_stall) begin
            rsp_stall  = 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) :
                                                       $urandom_range(0, 6);
         end else begin
            rsp_stall  = 1'b1;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
                                                       $urandom_range(0, 2);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      carriage_set_type seen;
      carriage_set_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         seen = '{rsp_carriage_a, rsp_carriage_b, rsp_carriage_c, rsp_out_of_reach};
         if (pending_carriages.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("result beat with nothing expected: a=%h b=%h c=%h oor=%b",
                        seen.a, seen.b, seen.c, seen.oor);
         end else begin
            want = pending_carriages.pop_front();
            if (seen.a !== want.a || seen.b !== want.b || seen.c !== want.c ||
                seen.oor !== want.oor) begin
               fault_count++;
               if (fault_count <= 10)
                  $display({"point %0d: expected a=%h b=%h c=%h oor=%b, ",
                            "got a=%h b=%h c=%h oor=%b"},
                           checked_count, want.a, want.b, want.c, want.oor,
                           seen.a, seen.b, seen.c, seen.oor);
            end
            checked_count++;
         end
      end
   end

   // main sequence
   initial begin
      coord_type     tx;
      coord_type     ty;
      coord_type     tz;
      longint        reach;
      longint        dx;
      longint        dy;
      int unsigned   mode;
      int unsigned   t;
      geom_pick_type current;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_target_x     = '0;
      req_target_y     = '0;
      req_target_z     = '0;
      csr_write        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      hold_off_request = 1'b0;
      quiet_left       = 0;
      fault_count      = 0;
      checked_count    = 0;
      far_count        = 0;
      clipped_count    = 0;
      settings_loaded  = 1;
      backpressure_cycles = 0;
      for (int i = 0; i < NUM_TOWERS; i++) begin
         tower_x_reg[i] = '0;
         tower_y_reg[i] = '0;
      end
      rod_reg    = '0;
      offset_reg = '0;

      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // directed table
      current = GEOM_RESET;
      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].geom != current) begin
            settle_pipeline();
            load_geometry(DIRECTED_ROWS[i].geom);
            current = DIRECTED_ROWS[i].geom;
         end
         send_point(DIRECTED_ROWS[i].x, DIRECTED_ROWS[i].y, DIRECTED_ROWS[i].z,
                    DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end

      // random points, mostly placed around a tower so the root is exercised
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle_pipeline();
         load_geometry(p == 3 ? GEOM_CORNER : (p == 5 ? GEOM_DELTA : GEOM_RANDOM));
         for (int n = 0; n < POINTS_PER_PHASE; n++) begin
            if (p == 1 && n == 30) hold_off_request = 1'b1;
            reach = longint'(rod_reg);
            t     = $urandom_range(0, NUM_TOWERS - 1);
            mode  = $urandom_range(0, 9);
            dx    = 0;
            dy    = 0;
            if (mode < 6) begin
               dx = longint'($urandom_range(0, 2 * reach)) - reach;
               dy = longint'($urandom_range(0, 2 * reach)) - reach;
            end else if (mode < 8) begin
               // on the reach circle along one axis, or one step past it
               dx = reach + longint'($urandom_range(0, 1));
               if ($urandom_range(0, 1)) dx = -dx;
               if ($urandom_range(0, 1)) begin
                  dy = dx;
                  dx = 0;
               end
            end
            if (mode < 8) begin
               tx = coord_type'(longint'(tower_x_reg[t]) + dx);
               ty = coord_type'(longint'(tower_y_reg[t]) + dy);
            end else begin
               tx = coord_type'($urandom);
               ty = coord_type'($urandom);
            end
            if ($urandom_range(0, 7) == 0)
               tz = $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
            else
               tz = coord_type'($urandom);
            send_point(tx, ty, tz, 1'b0, '0);
         end
      end

      settle_pipeline();
      repeat (NUM_STAGES + 4) @(negedge clock);

      $display("%0d points checked over %0d geometry settings",
               checked_count, settings_loaded);
      $display("%0d tower solutions out of reach, %0d carriages clipped",
               far_count, clipped_count);
      $display("input stalled for %0d cycles during the long output hold-off, %0d faults",
               backpressure_cycles, fault_count);
      if (fault_count == 0 && pending_carriages.size() == 0)
         $display("linear_delta_inverse_kinematics verification clean");
      else
         $display("linear_delta_inverse_kinematics verification failed");
      $finish;
   end

endmodule

[files.f]
hdl/ldik_pkg.sv
hdl/ldik_front.sv
hdl/ldik_root_cell.sv
hdl/ldik_output.sv
hdl/linear_delta_inverse_kinematics.sv
dv/linear_delta_inverse_kinematics_test.sv
